[hw/rtl/crtb_pkg.sv]
// Shared types and codes for the completion ring with take by id.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package crtb_pkg;

	localparam int CFG_W         = 7;
	localparam int RING_SIZE_RST = 64;

	typedef enum logic [1:0] {
		CMD_PUSH     = 2'd0,
		CMD_TAKE_ID  = 2'd1,
		CMD_TAKE_OLD = 2'd2
	} crtb_cmd_t;

	typedef enum logic [1:0] {
		RC_OK   = 2'd0,
		RC_MISS = 2'd1,
		RC_FULL = 2'd2
	} crtb_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OLD,
		ST_SCAN,
		ST_SWAP,
		ST_DONE
	} crtb_state_t;

	// stored entry: status in the top 16 bits, handle in the middle, id at the bottom
	typedef struct packed {
		logic [15:0] status;
		logic [31:0] handle;
		logic [15:0] id;
	} crtb_entry_t;

	typedef struct packed {
		logic        valid;
		logic        found;
		crtb_entry_t entry;
		crtb_code_t  code;
	} crtb_res_t;

endpackage

`default_nettype wire

[hw/rtl/crtb_mem.sv]
// Entry store: one write port, one read port, registered read data.
// Depends on crtb_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module crtb_mem
	import crtb_pkg::*;
#(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic        clk,
	input  wire logic        wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire crtb_entry_t wr_data,
	input  wire logic        rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output crtb_entry_t      rd_data
);

	crtb_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/crtb_ctrl.sv]
// Command sequencer: head/tail/count, id scan over the entry store, swap-remove.
// Depends on crtb_pkg; drives the ports of crtb_mem.
`timescale 1ns / 1ps
`default_nettype none

module crtb_ctrl
	import crtb_pkg::*;
#(
	parameter int RING_DEPTH = 64,
	localparam int IW = $clog2(RING_DEPTH),
	localparam int CW = $clog2(RING_DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire logic [1:0]       cmd,
	input  wire crtb_entry_t      req_entry,
	output crtb_res_t             res,
	input  wire logic             res_take,
	output logic                  mem_wr_en,
	output logic [IW-1:0]         mem_wr_addr,
	output crtb_entry_t           mem_wr_data,
	output logic                  mem_rd_en,
	output logic [IW-1:0]         mem_rd_addr,
	input  wire crtb_entry_t      mem_rd_data
);

	localparam int SW       = (CW > CFG_W) ? CW : CFG_W;
	localparam int SIZE_RST = (RING_DEPTH < RING_SIZE_RST) ? RING_DEPTH : RING_SIZE_RST;

	crtb_state_t state_q, state_nxt;

	logic [IW-1:0] head_q, tail_q, ptr_q;
	logic [CW-1:0] count_q, size_q, left_q;
	logic          pend_s1;
	logic [IW-1:0] pend_addr_s1;
	logic [IW-1:0] hit_addr_q;
	logic [15:0]   id_q;
	logic          res_found_q;
	crtb_entry_t   res_entry_q;
	crtb_code_t    res_code_q;

	logic          acc;
	logic          hit;
	logic          hit_at_head;
	logic          has_room;
	logic          is_empty;
	logic [SW-1:0] cfg_ext;
	logic [CW-1:0] cfg_size;

	function automatic logic [IW-1:0] nxt_idx(input logic [IW-1:0] i, input logic [CW-1:0] s);
		logic [CW-1:0] inc;
		begin
			inc = CW'(i) + CW'(1);
			return (inc == s) ? '0 : inc[IW-1:0];
		end
	endfunction

	assign acc         = req_valid && !req_stall;
	assign hit         = (state_q == ST_SCAN) && pend_s1 && (mem_rd_data.id == id_q);
	assign hit_at_head = (pend_addr_s1 == head_q);
	assign has_room    = (count_q < size_q);
	assign is_empty    = (count_q == '0);

	// saturate the written size to 1..RING_DEPTH
	assign cfg_ext = SW'(cfg_wr_data);
	always_comb begin
		if (cfg_ext == '0) begin
			cfg_size = CW'(1);
		end else if (cfg_ext > SW'(RING_DEPTH)) begin
			cfg_size = CW'(RING_DEPTH);
		end else begin
			cfg_size = cfg_ext[CW-1:0];
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (cmd)
						CMD_TAKE_ID:  state_nxt = is_empty ? ST_DONE : ST_SCAN;
						CMD_TAKE_OLD: state_nxt = is_empty ? ST_DONE : ST_OLD;
						default:      state_nxt = ST_DONE;
					endcase
				end
			end
			ST_OLD:  state_nxt = ST_DONE;
			ST_SCAN: begin
				if (hit) begin
					state_nxt = hit_at_head ? ST_DONE : ST_SWAP;
				end else if (left_q == '0 && !pend_s1) begin
					state_nxt = ST_DONE;
				end
			end
			ST_SWAP: state_nxt = ST_DONE;
			ST_DONE: begin
				if (res_take) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs and memory control
	always_comb begin
		req_stall   = (state_q != ST_IDLE);
		mem_wr_en   = 1'b0;
		mem_wr_addr = tail_q;
		mem_wr_data = req_entry;
		mem_rd_en   = 1'b0;
		mem_rd_addr = head_q;
		res.valid   = (state_q == ST_DONE);
		res.found   = res_found_q;
		res.entry   = res_entry_q;
		res.code    = res_code_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && cmd == CMD_PUSH && has_room) begin
					mem_wr_en = 1'b1;
				end
				if (acc && cmd == CMD_TAKE_OLD && !is_empty) begin
					mem_rd_en = 1'b1;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					// fetch the head word to fill the hole
					mem_rd_en = !hit_at_head;
				end else if (left_q != '0) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = ptr_q;
				end
			end
			ST_SWAP: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = hit_addr_q;
				mem_wr_data = mem_rd_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			size_q  <= CW'(SIZE_RST);
			ptr_q   <= '0;
			left_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				size_q  <= cfg_size;
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (acc && cmd == CMD_PUSH && has_room) begin
							tail_q  <= nxt_idx(tail_q, size_q);
							count_q <= count_q + CW'(1);
						end
						ptr_q   <= head_q;
						left_q  <= count_q;
						pend_s1 <= 1'b0;
					end
					ST_OLD: begin
						head_q  <= nxt_idx(head_q, size_q);
						count_q <= count_q - CW'(1);
					end
					ST_SCAN: begin
						if (hit) begin
							pend_s1 <= 1'b0;
							if (hit_at_head) begin
								head_q  <= nxt_idx(head_q, size_q);
								count_q <= count_q - CW'(1);
							end
						end else if (left_q != '0) begin
							pend_s1 <= 1'b1;
							ptr_q   <= nxt_idx(ptr_q, size_q);
							left_q  <= left_q - CW'(1);
						end else begin
							pend_s1 <= 1'b0;
						end
					end
					ST_SWAP: begin
						head_q  <= nxt_idx(head_q, size_q);
						count_q <= count_q - CW'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				id_q        <= req_entry.id;
				res_found_q <= 1'b0;
				res_entry_q <= '0;
				if (cmd == CMD_PUSH) begin
					res_code_q <= has_room ? RC_OK : RC_FULL;
				end else begin
					res_code_q <= RC_MISS;
				end
			end
			ST_OLD: begin
				res_found_q <= 1'b1;
				res_entry_q <= mem_rd_data;
				res_code_q  <= RC_OK;
			end
			ST_SCAN: begin
				pend_addr_s1 <= ptr_q;
				if (hit) begin
					hit_addr_q  <= pend_addr_s1;
					res_found_q <= 1'b1;
					res_entry_q <= mem_rd_data;
					res_code_q  <= RC_OK;
				end
			end
			default: begin
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= size_q)
		else $error("entry count above ring size");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(head_q) < size_q) && (CW'(tail_q) < size_q))
		else $error("head or tail outside the active ring");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !cfg_wr_en |=> state_q != ST_IDLE)
		else $error("accepted word left no trace in the sequencer");

	a_found_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.found |-> res.code == RC_OK)
		else $error("found result with a failure code");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !mem_wr_en)
		else $error("store written during an id scan");

endmodule

`default_nettype wire

[hw/rtl/completion_ring_take_by_id_top.sv]
// Top level of the completion ring: entry store, sequencer and result register.
// Depends on crtb_pkg, crtb_mem and crtb_ctrl.
//
//  channel   | valid / stall          | words
//  ----------+------------------------+--------------------------------------------
//  request   | req_valid / req_stall  | cmd, page_id, page_handle, page_status
//  response  | rsp_valid / rsp_stall  | found, out_id, out_handle, out_status,
//            |                        | result_code
//  config    | cfg_wr_en (no wait)    | cfg_wr_data (ring size)
//
// One command at a time. Push, empty take and unknown command go straight to the
// result; take-oldest reads the head word first.
// Take-by-id reads one stored word per cycle from head until it hits; a hit away
// from head also refills the hit slot from the head word, and a miss reads every
// stored word (at most RING_DEPTH).
// The sequencer is idle from the edge that loads the output register, so the next
// word is taken in the next cycle; a stalled output register holds the sequencer.
// Reset empties the ring and sets the size to the lesser of 64 and RING_DEPTH; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module completion_ring_take_by_id_top
	import crtb_pkg::*;
#(
	parameter int RING_DEPTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire logic [1:0]       cmd,
	input  wire logic [15:0]      page_id,
	input  wire logic [31:0]      page_handle,
	input  wire logic [15:0]      page_status,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output logic                  found,
	output logic [15:0]           out_id,
	output logic [31:0]           out_handle,
	output logic [15:0]           out_status,
	output logic [1:0]            result_code
);

	localparam int IW = $clog2(RING_DEPTH);

	crtb_entry_t   req_entry;
	crtb_res_t     res;
	logic          res_take;
	logic          out_free;
	logic          mem_wr_en;
	logic [IW-1:0] mem_wr_addr;
	crtb_entry_t   mem_wr_data;
	logic          mem_rd_en;
	logic [IW-1:0] mem_rd_addr;
	crtb_entry_t   mem_rd_data;

	assign req_entry.id     = page_id;
	assign req_entry.handle = page_handle;
	assign req_entry.status = page_status;

	crtb_mem #(
		.DEPTH (RING_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	crtb_ctrl #(
		.RING_DEPTH (RING_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.cmd         (cmd),
		.req_entry   (req_entry),
		.res         (res),
		.res_take    (res_take),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	// output register: load when empty or being drained this cycle
	assign out_free = !rsp_valid || !rsp_stall;
	assign res_take = res.valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (res_take) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			found       <= res.found;
			out_id      <= res.entry.id;
			out_handle  <= res.entry.handle;
			out_status  <= res.entry.status;
			result_code <= res.code;
		end
	end

endmodule

`default_nettype wire

[tb/completion_ring_take_by_id_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for completion_ring_take_by_id_top: a shadow ring predicts each
// response word, and responses are checked in order. Depends on crtb_pkg and the block RTL.

module completion_ring_take_by_id_top_tb;
	import crtb_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic        found;
		crtb_entry_t entry;
		crtb_code_t  code;
	} rsp_word_t;

	class ring_shadow;
		crtb_entry_t slots [DEPTH];
		int unsigned head;
		int unsigned tail;
		int unsigned count;
		int unsigned size_reg;
		rsp_word_t   due_words [$];
		int unsigned mismatches;

		function new();
			size_reg   = RING_SIZE_RST;
			head       = 0;
			tail       = 0;
			count      = 0;
			mismatches = 0;
		endfunction

		function int unsigned live_size();
			if (size_reg < 1) return 1;
			if (size_reg > DEPTH) return DEPTH;
			return size_reg;
		endfunction

		function int unsigned step_on(int unsigned i, int unsigned sz);
			return (i + 1 >= sz) ? 0 : i + 1;
		endfunction

		function void set_size(logic [CFG_W-1:0] v);
			size_reg = v;
			head     = 0;
			tail     = 0;
			count    = 0;
		endfunction

		// id of a random occupied slot, or a random id when the ring is empty
		function logic [15:0] pick_id();
			int unsigned idx;
			if (count == 0) return 16'($urandom);
			idx = (head + $urandom_range(0, count - 1)) % live_size();
			return slots[idx].id;
		endfunction

		function void predict_word(logic [1:0] c, logic [15:0] id, logic [31:0] handle,
				logic [15:0] status);
			int unsigned sz;
			int unsigned h;
			int unsigned n;
			bit          hit;
			rsp_word_t   w;
			sz     = live_size();
			w      = '0;
			w.code = RC_MISS;
			if (head >= sz) head = 0;
			if (tail >= sz) tail = 0;
			if (count > sz) count = sz;
			case (c)
				CMD_PUSH: begin
					if (count >= sz) begin
						w.code = RC_FULL;
					end else begin
						slots[tail].id     = id;
						slots[tail].handle = handle;
						slots[tail].status = status;
						tail   = step_on(tail, sz);
						count++;
						w.code = RC_OK;
					end
				end
				CMD_TAKE_ID: begin
					h   = head;
					hit = 0;
					for (n = 0; n < count && !hit; n++) begin
						if (slots[h].id == id) begin
							hit     = 1;
							w.found = 1'b1;
							w.entry = slots[h];
							w.code  = RC_OK;
							// refill the hit slot from head, then advance head
							slots[h] = slots[head];
							head     = step_on(head, sz);
							count--;
						end else begin
							h = step_on(h, sz);
						end
					end
				end
				CMD_TAKE_OLD: begin
					if (count != 0) begin
						w.found = 1'b1;
						w.entry = slots[head];
						w.code  = RC_OK;
						head    = step_on(head, sz);
						count--;
					end
				end
				default: ;
			endcase
			due_words.push_back(w);
		endfunction

		function void check_word(rsp_word_t got);
			rsp_word_t want;
			if (due_words.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: response word with none due: %h", $realtime, got);
				return;
			end
			want = due_words.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN) begin
					$display("%0t: mismatch", $realtime);
					$display("  expected found=%0d id=%h handle=%h status=%h code=%0d",
						want.found, want.entry.id, want.entry.handle,
						want.entry.status, want.code);
					$display("  got      found=%0d id=%h handle=%h status=%h code=%0d",
						got.found, got.entry.id, got.entry.handle,
						got.entry.status, got.code);
				end
			end
		endfunction
	endclass

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;
	logic             req_valid   = 1'b0;
	logic             req_stall;
	logic [1:0]       cmd         = '0;
	logic [15:0]      page_id     = '0;
	logic [31:0]      page_handle = '0;
	logic [15:0]      page_status = '0;
	logic             rsp_valid;
	logic             rsp_stall   = 1'b0;
	logic             found;
	logic [15:0]      out_id;
	logic [31:0]      out_handle;
	logic [15:0]      out_status;
	logic [1:0]       result_code;

	ring_shadow shadow = new();
	bit calm          = 1'b0;
	bit filling       = 1'b1;
	bit want_pressure = 1'b0;

	completion_ring_take_by_id_top #(
		.RING_DEPTH(DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.page_id    (page_id),
		.page_handle(page_handle),
		.page_status(page_status),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.found      (found),
		.out_id     (out_id),
		.out_handle (out_handle),
		.out_status (out_status),
		.result_code(result_code)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// offer one request word and hold it until accepted
	task automatic send_word(input logic [1:0] c, input logic [15:0] id,
			input logic [31:0] handle, input logic [15:0] status);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_valid   <= 1'b1;
		cmd         <= c;
		page_id     <= id;
		page_handle <= handle;
		page_status <= status;
		do @(posedge clk); while (req_stall);
		shadow.predict_word(c, id, handle, status);
	endtask

	// drain the ring's responses, then write the size
	task automatic write_size(input logic [CFG_W-1:0] v);
		req_valid <= 1'b0;
		while (shadow.due_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow.set_size(v);
	endtask

	task automatic random_word();
		logic [1:0]  c;
		logic [15:0] id;
		int unsigned r;
		if (shadow.count >= shadow.live_size()) filling = 1'b0;
		else if (shadow.count == 0) filling = 1'b1;
		r = $urandom_range(0, 99);
		if (r < 3) c = CMD_SPARE;
		else if (r < (filling ? 85 : 25)) c = CMD_PUSH;
		else if ($urandom_range(0, 3) == 0) c = CMD_TAKE_OLD;
		else c = CMD_TAKE_ID;
		r = $urandom_range(0, 9);
		if (c == CMD_TAKE_ID && r < 7) id = shadow.pick_id();
		else if (r < 4) id = 16'($urandom_range(0, 15));
		else if (r == 9) id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		else id = 16'($urandom);
		send_word(c, id, $urandom, 16'($urandom));
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] sz, input int n, input bit press);
		write_size(sz);
		for (int i = 0; i < n; i++) begin
			if (press && i == n / 2) want_pressure = 1'b1;
			random_word();
		end
	endtask

	// response side: check each accepted word, stall in bursts
	initial begin
		int unsigned hold_left;
		rsp_word_t   got;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				got = {found, out_status, out_handle, out_id, result_code};
				shadow.check_word(got);
			end
			if (want_pressure) begin
				want_pressure = 1'b0;
				hold_left     = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(0, 8);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		#1_000_000;
		$display("[completion_ring_take_by_id_top] ERROR");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset size: empty takes, spare command, field extremes, duplicate ids
		send_word(CMD_TAKE_OLD, 16'h0000, 32'h0, 16'h0);
		send_word(CMD_TAKE_ID, 16'h0000, 32'h0, 16'h0);
		send_word(CMD_SPARE, 16'h0000, 32'h0, 16'h0);
		send_word(CMD_PUSH, 16'h0000, 32'h0000_0000, 16'h0000);
		send_word(CMD_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(CMD_PUSH, 16'h0005, 32'hA5A5_A5A5, 16'h1111);
		send_word(CMD_PUSH, 16'h0005, 32'h5A5A_5A5A, 16'h2222);
		send_word(CMD_TAKE_ID, 16'h0005, 32'h0, 16'h0);
		send_word(CMD_TAKE_ID, 16'h1234, 32'h0, 16'h0);
		send_word(CMD_SPARE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(CMD_TAKE_ID, 16'hFFFF, 32'h0, 16'h0);
		send_word(CMD_TAKE_OLD, 16'h0000, 32'h0, 16'h0);
		send_word(CMD_TAKE_OLD, 16'h0000, 32'h0, 16'h0);
		send_word(CMD_TAKE_OLD, 16'h0000, 32'h0, 16'h0);

		// two slots: full push, hit away from head, tail wrap
		write_size(7'd2);
		send_word(CMD_PUSH, 16'h0001, 32'h1111_0001, 16'h0101);
		send_word(CMD_PUSH, 16'h0002, 32'h2222_0002, 16'h0202);
		send_word(CMD_PUSH, 16'h0003, 32'h3333_0003, 16'h0303);
		send_word(CMD_TAKE_ID, 16'h0002, 32'h0, 16'h0);
		send_word(CMD_PUSH, 16'h0004, 32'h4444_0004, 16'h0404);
		send_word(CMD_TAKE_ID, 16'h0001, 32'h0, 16'h0);
		send_word(CMD_TAKE_OLD, 16'h0000, 32'h0, 16'h0);

		// size zero acts as one slot
		write_size(7'd0);
		send_word(CMD_PUSH, 16'h0007, 32'h7777_7777, 16'h0707);
		send_word(CMD_PUSH, 16'h0008, 32'h8888_8888, 16'h0808);
		send_word(CMD_TAKE_ID, 16'h0007, 32'h0, 16'h0);
		send_word(CMD_TAKE_OLD, 16'h0000, 32'h0, 16'h0);

		run_phase(7'd127, 220, 1'b1);
		run_phase(7'd1, 110, 1'b0);
		run_phase(7'd3, 120, 1'b0);
		run_phase(7'd8, 120, 1'b0);
		run_phase(7'($urandom_range(1, DEPTH)), 150, 1'b0);
		calm = 1'b1;
		run_phase(7'd64, 110, 1'b0);

		req_valid <= 1'b0;
		while (shadow.due_words.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.due_words.size() == 0) begin
			$display("[completion_ring_take_by_id_top] OK");
		end else begin
			$display("[completion_ring_take_by_id_top] ERROR");
		end
		$finish;
	end

endmodule
